FILE: hw/rtl/eea_pkg.sv
`default_nettype none

package eea_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned LineW       = 16;
  localparam int unsigned PoleW       = 6;
  localparam int unsigned OffsetW     = 16;
  localparam int unsigned AngleW      = 15;
  localparam int unsigned PosW        = 32;
  localparam int unsigned DeltaW      = 16;
  localparam int unsigned ScaleW      = 31;
  localparam int unsigned DividendW   = 31;
  localparam int unsigned DivisorW    = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned AngleShift  = 15;
  localparam int unsigned HallMultW   = 4;

  localparam logic [DivisorW-1:0]  HallSectors = DivisorW'(12);
  localparam logic [DividendW-1:0] ScaleNum    = DividendW'(1) << 30;
  localparam logic [ScaleW-1:0]    ScaleSat    = ScaleW'(31'h7FFF_FFFF);

  // floor(x / 12) for 16-bit x as (x * SectRecip) >> SectShift
  localparam logic [LineW-1:0]     SectRecip   = LineW'(43691);
  localparam int unsigned          SectShift   = 19;

  localparam logic [LineW-1:0] LineCountRst = LineW'(10000);
  localparam logic [PoleW-1:0] PolePairsRst = PoleW'(4);

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_INDEX  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_COUNT   = 2'd0,
    REG_POLE_PAIRS   = 2'd1,
    REG_CALIB_OFFSET = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quotient;
  } div_rsp_t;

  // hall code to odd sector multiple, zero for invalid codes
  function automatic logic [HallMultW-1:0] hall_mult(input logic [2:0] hall);
    logic [HallMultW-1:0] m;
    unique case (hall)
      3'd1:    m = HallMultW'(1);
      3'd3:    m = HallMultW'(3);
      3'd2:    m = HallMultW'(5);
      3'd6:    m = HallMultW'(7);
      3'd4:    m = HallMultW'(9);
      3'd5:    m = HallMultW'(11);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/eea_div.sv
`default_nettype none

module eea_div
  import eea_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(DividendW);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DividendW-1:0] dvd_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  dvs_q;
  logic [DivisorW-1:0]  rem_q;

  logic [DivisorW:0]    rem_sh;
  logic                 ge;
  logic [DivisorW:0]    rem_sub;
  logic [DivisorW-1:0]  rem_d;

  // one restoring step per cycle
  assign rem_sh  = {rem_q, dvd_q[DividendW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign rem_d   = ge ? rem_sub[DivisorW-1:0] : rem_sh[DivisorW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DividendW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DividendW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DividendW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q) && $past(cnt_q) == '0)
    else $error("divider done without final step");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/encoder_electrical_angle_unit.sv
`default_nettype none

// A sample passes the wrap-high, wrap-low, multiply and angle states, an index
// or unused action none, and an init runs two 31-step divisions on one shared
// bit-serial divider and a position seed step; each then waits in the output
// state while a held result is stalled. No new item is taken until idle.
// The sample path is add, two wrap steps, 32x31 multiply, pole-pair multiply.
// Reset (async, active low): config regs to 10000/4/0, tracking state cleared.
module encoder_electrical_angle_unit
  import eea_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           in_action_i,
  input  wire logic [CountWidth-1:0] in_encoder_count_i,
  input  wire logic [2:0]           in_hall_state_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [AngleW-1:0]         out_elec_angle_o,
  output logic signed [PosW-1:0]    out_position_feedback_o,
  output logic signed [DeltaW-1:0]  out_count_delta_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DIV_SCALE = 4'd1;
  localparam logic [3:0] ST_DIV_POLE  = 4'd2;
  localparam logic [3:0] ST_DIV_SECT  = 4'd3;
  localparam logic [3:0] ST_WRAP_HI   = 4'd4;
  localparam logic [3:0] ST_WRAP_LO   = 4'd5;
  localparam logic [3:0] ST_MUL       = 4'd6;
  localparam logic [3:0] ST_ANGLE     = 4'd7;
  localparam logic [3:0] ST_OUT       = 4'd8;

  logic [LineW-1:0]       line_count_q;
  logic [PoleW-1:0]       pole_pairs_q;
  logic [OffsetW-1:0]     calib_offset_q;

  logic [3:0]             state_q, state_d;
  logic [CountWidth-1:0]  prev_count_q;
  logic [PosW-1:0]        pos_q;
  logic [PosW-1:0]        accum_q;
  logic [ScaleW-1:0]      scale_q;
  logic [AngleW-1:0]      angle_q;
  logic [DeltaW-1:0]      delta_q;
  logic [2:0]             hall_q;
  logic [PosW-1:0]        prod_q;
  logic [LineW-1:0]       step_q;

  logic                   out_valid_q;
  logic [AngleW-1:0]      out_angle_q;
  logic [PosW-1:0]        out_fb_q;
  logic [DeltaW-1:0]      out_delta_q;

  logic                   in_xfer;
  logic                   out_free;
  logic [CountWidth-1:0]  cur_count;
  logic [CountWidth-1:0]  diff;
  logic [PosW-1:0]        delta_full;
  logic [PosW-1:0]        line_ext;
  logic [HallMultW-1:0]   mult;
  logic [PosW-1:0]        sect_prod;
  logic [LineW-1:0]       step;
  logic [PosW-1:0]        seed_pos;
  logic [PosW-1:0]        scale_pos;
  logic [PosW-PoleW-1:0]  angle_prod;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cur_count  = CountWidth'(in_encoder_count_i);
  assign diff       = prev_count_q - cur_count;
  assign delta_full = PosW'(signed'(diff));
  assign line_ext   = PosW'(line_count_q);

  assign mult      = hall_mult(hall_q);
  assign sect_prod = PosW'(div_rsp.quotient[LineW-1:0]) * PosW'(SectRecip);
  assign step      = (line_count_q != '0 && pole_pairs_q != '0) ?
                     LineW'(sect_prod >> SectShift) : '0;
  assign seed_pos  = PosW'(step_q * LineW'(mult)) + PosW'(calib_offset_q);

  assign scale_pos  = PosW'(PosW'(scale_q) * pos_q);
  assign angle_prod = prod_q[PosW-1:AngleShift] * (PosW-PoleW)'(pole_pairs_q);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = ScaleNum;
    div_req.divisor  = line_count_q;
    unique case (state_q)
      ST_IDLE: begin
        div_req.start = in_xfer && in_action_i == ACT_INIT;
      end
      ST_DIV_SCALE: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DividendW'(line_count_q);
        div_req.divisor  = DivisorW'(pole_pairs_q);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  eea_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_action_i)
            ACT_INIT:   state_d = ST_DIV_SCALE;
            ACT_SAMPLE: state_d = ST_WRAP_HI;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_DIV_SCALE: if (div_rsp.done) state_d = ST_DIV_POLE;
      ST_DIV_POLE:  if (div_rsp.done) state_d = ST_DIV_SECT;
      ST_DIV_SECT:  state_d = ST_OUT;
      ST_WRAP_HI:   state_d = ST_WRAP_LO;
      ST_WRAP_LO:   state_d = ST_MUL;
      ST_MUL:       state_d = ST_ANGLE;
      ST_ANGLE:     state_d = ST_OUT;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q   <= LineCountRst;
      pole_pairs_q   <= PolePairsRst;
      calib_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_COUNT:   line_count_q   <= cfg_data_i[LineW-1:0];
        REG_POLE_PAIRS:   pole_pairs_q   <= cfg_data_i[PoleW-1:0];
        REG_CALIB_OFFSET: calib_offset_q <= cfg_data_i[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_count_q <= '0;
      pos_q        <= '0;
      accum_q      <= '0;
      scale_q      <= '0;
      angle_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_action_i == ACT_INIT) begin
              prev_count_q <= '0;
            end else if (in_action_i == ACT_SAMPLE) begin
              prev_count_q <= cur_count;
              accum_q      <= accum_q + delta_full;
              pos_q        <= pos_q + delta_full;
            end else if (in_action_i == ACT_INDEX) begin
              pos_q <= PosW'(calib_offset_q);
            end
          end
        end
        ST_DIV_SCALE: begin
          if (div_rsp.done) begin
            scale_q <= (line_count_q == '0) ? ScaleSat : div_rsp.quotient;
          end
        end
        ST_DIV_SECT: begin
          if (mult != '0) begin
            pos_q <= seed_pos;
          end
        end
        ST_WRAP_HI: begin
          if (!pos_q[PosW-1] && pos_q > line_ext) begin
            pos_q <= pos_q - line_ext;
          end
        end
        ST_WRAP_LO: begin
          if (pos_q[PosW-1]) begin
            pos_q <= pos_q + line_ext;
          end
        end
        ST_ANGLE: begin
          angle_q <= angle_prod[AngleW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hall_q  <= in_hall_state_i;
      delta_q <= (in_action_i == ACT_SAMPLE) ? delta_full[DeltaW-1:0] : '0;
    end
    if (state_q == ST_DIV_POLE && div_rsp.done) begin
      step_q <= step;
    end
    if (state_q == ST_MUL) begin
      prod_q <= scale_pos;
    end
    if (state_q == ST_OUT && out_free) begin
      out_angle_q <= angle_q;
      out_fb_q    <= accum_q;
      out_delta_q <= delta_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_elec_angle_o        = out_angle_q;
  assign out_position_feedback_o = signed'(out_fb_q);
  assign out_count_delta_o       = signed'(out_delta_q);

`ifndef ASSERT_OFF
  a_sample_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_action_i == ACT_SAMPLE |=> state_q == ST_WRAP_HI)
    else $error("sample transfer did not enter wrap step");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV_SCALE || state_q == ST_DIV_POLE ||
                     state_q == ST_DIV_SECT)
    else $error("divider result outside init sequence");
  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result valid raised outside output state");
  a_scale_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_SCALE && div_rsp.done && line_count_q == '0
      |=> scale_q == ScaleSat)
    else $error("zero line count did not saturate scale");
`endif

endmodule

`default_nettype wire

FILE: test/tb_encoder_electrical_angle_unit.sv
`timescale 1ns / 1ps

module tb_encoder_electrical_angle_unit;
  import eea_pkg::*;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit = 600000;

  typedef struct {
    action_e     action;
    logic [15:0] count;
    logic [2:0]  hall;
  } enc_item_t;

  typedef struct {
    logic [AngleW-1:0] angle;
    logic [PosW-1:0]   fb;
    logic [DeltaW-1:0] delta;
  } angle_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          in_action_i = '0;
  logic [15:0]         in_encoder_count_i = '0;
  logic [2:0]          in_hall_state_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [AngleW-1:0]   out_elec_angle_o;
  logic signed [PosW-1:0]   out_position_feedback_o;
  logic signed [DeltaW-1:0] out_count_delta_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  encoder_electrical_angle_unit dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_action_i            (in_action_i),
    .in_encoder_count_i     (in_encoder_count_i),
    .in_hall_state_i        (in_hall_state_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_elec_angle_o       (out_elec_angle_o),
    .out_position_feedback_o(out_position_feedback_o),
    .out_count_delta_o      (out_count_delta_o),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  enc_item_t     pend_q[$];
  angle_result_t angle_exp_q[$];
  enc_item_t     cur_item;

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;
  int unsigned hold_cnt = 0;
  int errors = 0;
  int n_checked = 0;
  int n_init = 0;
  int n_sample = 0;
  int n_index = 0;
  int n_unused = 0;
  int unsigned cycle_cnt = 0;

  // tracker copy of the block
  logic [LineW-1:0]   cfg_line = LineCountRst;
  logic [PoleW-1:0]   cfg_poles = PolePairsRst;
  logic [OffsetW-1:0] cfg_offset = '0;
  logic [15:0]        trk_prev = '0;
  logic [31:0]        trk_pos = '0;
  logic [31:0]        trk_accum = '0;
  logic [ScaleW-1:0]  trk_scale = '0;
  logic [AngleW-1:0]  trk_angle = '0;

  function automatic void predict_angle(input enc_item_t it);
    angle_result_t r;
    logic [15:0] d16;
    logic [15:0] step;
    logic [31:0] d32;
    logic [31:0] prod;
    logic [31:0] scaled;
    logic [3:0]  mult;
    d32 = '0;
    case (it.action)
      ACT_INIT: begin
        n_init++;
        step = '0;
        if (cfg_line == '0) begin
          trk_scale = ScaleSat;
        end else begin
          trk_scale = ScaleW'(32'h4000_0000 / {16'd0, cfg_line});
          if (cfg_poles != '0) step = (cfg_line / {10'd0, cfg_poles}) / HallSectors;
        end
        trk_prev = '0;
        case (it.hall)
          3'd1: mult = 4'd1;
          3'd3: mult = 4'd3;
          3'd2: mult = 4'd5;
          3'd6: mult = 4'd7;
          3'd4: mult = 4'd9;
          3'd5: mult = 4'd11;
          default: mult = 4'd0;
        endcase
        if (mult != 4'd0) trk_pos = {16'd0, step} * {28'd0, mult} + {16'd0, cfg_offset};
      end
      ACT_SAMPLE: begin
        n_sample++;
        d16 = trk_prev - it.count;
        d32 = {{16{d16[15]}}, d16};
        trk_prev = it.count;
        trk_accum = trk_accum + d32;
        trk_pos = trk_pos + d32;
        if (!trk_pos[31] && trk_pos > {16'd0, cfg_line}) trk_pos = trk_pos - {16'd0, cfg_line};
        if (trk_pos[31]) trk_pos = trk_pos + {16'd0, cfg_line};
        prod = {1'b0, trk_scale} * trk_pos;
        scaled = (prod >> AngleShift) * {26'd0, cfg_poles};
        trk_angle = scaled[AngleW-1:0];
      end
      ACT_INDEX: begin
        n_index++;
        trk_pos = {16'd0, cfg_offset};
      end
      default: n_unused++;
    endcase
    r.angle = trk_angle;
    r.fb = trk_accum;
    r.delta = d32[15:0];
    angle_exp_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_angle(cur_item);
      if (!in_valid_i || !in_stall_o) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = pend_q.pop_front();
          in_valid_i <= 1'b1;
          in_action_i <= cur_item.action;
          in_encoder_count_i <= cur_item.count;
          in_hall_state_i <= cur_item.hall;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_hold <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      rx_hold <= (hold_cnt != 1);
    end else if (hold_req) begin
      hold_cnt <= HoldCycles;
      rx_hold <= 1'b1;
    end
  end

  // monitor
  angle_result_t got_exp;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (angle_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, angle %0d feedback %0d delta %0d", $time,
                   out_elec_angle_o, out_position_feedback_o, out_count_delta_o);
        end else begin
          got_exp = angle_exp_q.pop_front();
          n_checked++;
          if (out_elec_angle_o !== got_exp.angle) begin
            errors++;
            $display("%0t: elec_angle expected %0d, got %0d", $time, got_exp.angle,
                     out_elec_angle_o);
          end
          if (out_position_feedback_o !== got_exp.fb) begin
            errors++;
            $display("%0t: position_feedback expected %0d, got %0d", $time,
                     $signed(got_exp.fb), out_position_feedback_o);
          end
          if (out_count_delta_o !== got_exp.delta) begin
            errors++;
            $display("%0t: count_delta expected %0d, got %0d", $time,
                     $signed(got_exp.delta), out_count_delta_o);
          end
        end
      end
      out_stall_i <= rx_hold || ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout, %0d items pending, %0d results outstanding", $time,
               pend_q.size(), angle_exp_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_item(input action_e a, input logic [15:0] c, input logic [2:0] h);
    pend_q.push_back('{a, c, h});
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pend_q.size() != 0 || angle_exp_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_LINE_COUNT:   cfg_line = val;
      REG_POLE_PAIRS:   cfg_poles = val[PoleW-1:0];
      REG_CALIB_OFFSET: cfg_offset = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly tracking runs: init, then small count steps, with some noise
  task automatic gen_track_items(input int n);
    int r;
    logic [15:0] enc;
    enc = '0;
    push_item(ACT_INIT, 16'($urandom), 3'($urandom_range(1, 6)));
    for (int i = 1; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_item(ACT_INIT, 16'($urandom), 3'($urandom));
        enc = '0;
      end else if (r < 8) begin
        push_item(ACT_INDEX, 16'($urandom), 3'($urandom));
      end else if (r < 10) begin
        push_item(ACT_NONE, 16'($urandom), 3'($urandom));
      end else if (r < 16) begin
        enc = 16'($urandom);
        push_item(ACT_SAMPLE, enc, 3'($urandom));
      end else begin
        enc = enc + 16'($urandom_range(0, 400)) - 16'd200;
        push_item(ACT_SAMPLE, enc, 3'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] line_v;
    logic [15:0] pole_v;
    logic [15:0] off_v;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config, scale still zero
    push_item(ACT_SAMPLE, 16'h0010, 3'd0);
    push_item(ACT_NONE, 16'hFFFF, 3'd7);
    push_item(ACT_INDEX, 16'h5A5A, 3'd2);
    for (int h = 0; h < 8; h++) push_item(ACT_INIT, 16'hA5A5, 3'(h));
    push_item(ACT_SAMPLE, 16'h8000, 3'd0);
    push_item(ACT_SAMPLE, 16'h8001, 3'd0);
    push_item(ACT_SAMPLE, 16'h0001, 3'd0);
    push_item(ACT_INIT, 16'h0000, 3'd1);
    push_item(ACT_SAMPLE, 16'h8001, 3'd0);
    push_item(ACT_SAMPLE, 16'h0000, 3'd0);
    push_item(ACT_SAMPLE, 16'hFFFF, 3'd0);
    wait_idle();

    // zero line count and zero pole pairs
    write_reg(REG_LINE_COUNT, 16'd0);
    write_reg(REG_POLE_PAIRS, 16'd0);
    write_reg(REG_CALIB_OFFSET, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    @(negedge clk_i);
    push_item(ACT_INIT, 16'h1234, 3'd5);
    push_item(ACT_SAMPLE, 16'h0064, 3'd0);
    push_item(ACT_INDEX, 16'h0000, 3'd0);
    push_item(ACT_SAMPLE, 16'hFF00, 3'd0);
    wait_idle();

    write_reg(REG_LINE_COUNT, 16'hFFFF);
    write_reg(REG_POLE_PAIRS, 16'd32);
    write_reg(REG_CALIB_OFFSET, 16'd0);
    @(negedge clk_i);
    push_item(ACT_INIT, 16'h0000, 3'd6);
    push_item(ACT_SAMPLE, 16'h8000, 3'd0);
    push_item(ACT_SAMPLE, 16'h0000, 3'd0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin line_v = 16'd10000; pole_v = 16'd4; off_v = 16'd123; end
        1: begin line_v = 16'd1; pole_v = 16'd1; off_v = 16'd0; end
        2: begin line_v = 16'hFFFF; pole_v = 16'd32; off_v = 16'hFFFF; end
        3: begin
          line_v = 16'($urandom_range(1, 65535));
          pole_v = 16'($urandom_range(1, 32));
          off_v = 16'($urandom);
        end
        4: begin
          line_v = 16'($urandom_range(2, 200));
          pole_v = 16'($urandom_range(1, 32));
          off_v = 16'($urandom_range(0, 300));
        end
        default: begin line_v = 16'd4096; pole_v = 16'd7; off_v = 16'd2048; end
      endcase
      write_reg(REG_LINE_COUNT, line_v);
      write_reg(REG_POLE_PAIRS, pole_v);
      write_reg(REG_CALIB_OFFSET, off_v);
      @(negedge clk_i);
      case (p)
        1, 5: begin send_idle_pct = 68; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 68; end
        3: begin send_idle_pct = 20; stall_pct = 20; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      gen_track_items(300);
      if (p == 3) begin
        @(posedge clk_i);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (angle_exp_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, angle_exp_q.size());
    end
    $display("Checked %0d results: %0d inits, %0d samples, %0d index pulses, %0d unused codes",
             n_checked, n_init, n_sample, n_index, n_unused);
    $display("Settings swept from zero line count and pole pairs up to 65535 and 32");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
